// ----- rtl/core/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLKRST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");

`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: label");

`else

`define ASSERT_CLKRST(label, clk, rst, prop)

`define ASSERT_CLK(label, clk, prop)

`endif

`endif

// ----- rtl/core/rcdt_pkg.sv -----
package rcdt_pkg;

   localparam int POSITIONS  = 16384;
   localparam int POS_BITS   = $clog2(POSITIONS);
   localparam int DEPTH_BITS = 16;

   localparam int START_BITS   = 14;
   localparam int LENGTH_BITS  = 15;
   localparam int REGION_BITS  = 15;
   localparam int TARGET_BITS  = 16;
   localparam int READS_BITS   = 24;
   localparam int SUM_BITS     = 30;
   localparam int COVER_BITS   = 15;
   localparam int FRAC_BITS    = 8;
   localparam int PROD_BITS    = TARGET_BITS + COVER_BITS;
   localparam int CMP_BITS     = SUM_BITS + FRAC_BITS;
   localparam int END_BITS     = LENGTH_BITS + 1;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET = 1'd1;

   localparam logic [REGION_BITS-1:0] REGION_RESET = 15'd10000;
   localparam logic [TARGET_BITS-1:0] TARGET_RESET = 16'd512;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_MUL,
      ST_RESP
   } state_type;

endpackage

// ----- rtl/core/read_coverage_depth_tracker_top.sv -----
// read depth coverage tracker
//
// request channel: a read (req_read_start, req_read_length) is taken at a
// rising edge with start high and busy low. each request gives one response
// on the rsp_ ports, valid for exactly one cycle while rsp_valid is high;
// the receiver cannot stall, so the response is simply presented once.
// csr port: csr_write_enable with csr_index and csr_write_data writes a
// register at the edge, index 0 is region_length, index 1 is target_coverage.
//
// timing: the depth store is a single-port-per-side ram with a registered
// read. a read of length L walks its positions one per cycle, read then
// write back in the next cycle, so the ram port sets the rate. busy drops
// the cycle after the response, so the next read is taken only then. a read
// out of range skips the walk and goes straight to the multiply step and
// the response.
//
// reset: synchronous, active high. after reset a clearing pass zeroes all
// 16384 entries of the depth store, one entry per cycle, with busy high.
// csr writes are taken during the pass.
module read_coverage_depth_tracker_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rcdt_pkg::START_BITS-1:0]       req_read_start,
   input  logic [rcdt_pkg::LENGTH_BITS-1:0]      req_read_length,
   output logic                                  rsp_valid,
   output logic [rcdt_pkg::READS_BITS-1:0]       rsp_reads_seen,
   output logic [rcdt_pkg::SUM_BITS-1:0]         rsp_total_depth,
   output logic [rcdt_pkg::COVER_BITS-1:0]       rsp_covered_positions,
   output logic                                  rsp_target_reached,
   output logic                                  rsp_range_error,
   input  logic                                  csr_write_enable,
   input  logic [rcdt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rcdt_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import rcdt_pkg::*;

`include "assert_macros.svh"

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
   localparam logic [COVER_BITS-1:0] COVER_MAX = '1;
   localparam logic [READS_BITS-1:0] READS_MAX = '1;
   localparam logic [POS_BITS-1:0]   CLR_LAST  = '1;
   localparam logic [REGION_BITS-1:0] REGION_CAP = REGION_BITS'(POSITIONS);

   // control state
   state_type                 state_ff, state_in;
   logic [POS_BITS-1:0]       clr_ff, clr_in;
   logic                      pend_ff, pend_in;

   // configuration
   logic [REGION_BITS-1:0]    region_ff, region_in;
   logic [TARGET_BITS-1:0]    target_ff, target_in;

   // running totals
   logic [SUM_BITS-1:0]       sum_ff, sum_in;
   logic [COVER_BITS-1:0]     cover_ff, cover_in;
   logic [READS_BITS-1:0]     reads_ff, reads_in;
   logic                      err_ff, err_in;

   // walk over the read
   logic [POS_BITS-1:0]       addr_ff, addr_in;
   logic [LENGTH_BITS-1:0]    remain_ff, remain_in;
   logic [POS_BITS-1:0]       wr_addr_ff, wr_addr_in;
   logic [PROD_BITS-1:0]      prod_ff, prod_in;

   // depth store
   logic [DEPTH_BITS-1:0]     depth_mem [POSITIONS];
   logic [DEPTH_BITS-1:0]     rdata_ff;
   logic                      mem_re;
   logic                      mem_we;
   logic [POS_BITS-1:0]       mem_waddr;
   logic [DEPTH_BITS-1:0]     mem_wdata;

   logic                      accept;
   logic [REGION_BITS-1:0]    region_eff;
   logic [END_BITS-1:0]       read_end;
   logic                      out_of_range;
   logic                      bump;

   // a read must fit in min(region_length, POSITIONS)
   assign region_eff   = (region_ff > REGION_CAP) ? REGION_CAP : region_ff;
   assign read_end     = END_BITS'(req_read_start) + END_BITS'(req_read_length);
   assign out_of_range = read_end > END_BITS'(region_eff);
   assign accept       = start && !busy;

   // counter coming back from the ram is incremented unless saturated
   assign bump = (state_ff == ST_RUN) && pend_ff && (rdata_ff != DEPTH_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = out_of_range ? ST_MUL : ST_RUN;
            end
         end
         ST_RUN: begin
            // for a non-empty read the last position was issued the cycle before; its write lands now
            if (remain_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs and ram strobes
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = wr_addr_ff;
      mem_wdata = rdata_ff + DEPTH_BITS'(1);
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_RUN: begin
            mem_re = (remain_ff != '0);
            mem_we = bump;
         end
         ST_MUL: begin
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      clr_in     = clr_ff;
      pend_in    = 1'b0;
      region_in  = region_ff;
      target_in  = target_ff;
      sum_in     = sum_ff;
      cover_in   = cover_ff;
      reads_in   = reads_ff;
      err_in     = err_ff;
      addr_in    = addr_ff;
      remain_in  = remain_ff;
      wr_addr_in = wr_addr_ff;
      prod_in    = prod_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_REGION: region_in = csr_write_data[REGION_BITS-1:0];
            CSR_TARGET: target_in = csr_write_data[TARGET_BITS-1:0];
            default: begin
            end
         endcase
      end

      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + POS_BITS'(1);
      end

      if (accept) begin
         err_in    = out_of_range;
         addr_in   = req_read_start[POS_BITS-1:0];
         remain_in = out_of_range ? '0 : req_read_length;
         if (!out_of_range && reads_ff != READS_MAX) begin
            reads_in = reads_ff + READS_BITS'(1);
         end
      end

      if (state_ff == ST_RUN) begin
         // issue side: one ram read per cycle
         if (remain_ff != '0) begin
            pend_in    = 1'b1;
            wr_addr_in = addr_ff;
            addr_in    = addr_ff + POS_BITS'(1);
            remain_in  = remain_ff - LENGTH_BITS'(1);
         end
         // write-back side: totals follow the counter that was bumped
         if (bump) begin
            if (sum_ff != SUM_MAX) begin
               sum_in = sum_ff + SUM_BITS'(1);
            end
            if (rdata_ff == '0 && cover_ff != COVER_MAX) begin
               cover_in = cover_ff + COVER_BITS'(1);
            end
         end
      end

      if (state_ff == ST_MUL) begin
         prod_in = PROD_BITS'(target_ff) * PROD_BITS'(cover_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         pend_ff   <= 1'b0;
         region_ff <= REGION_RESET;
         target_ff <= TARGET_RESET;
         sum_ff    <= '0;
         cover_ff  <= '0;
         reads_ff  <= '0;
         err_ff    <= 1'b0;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pend_ff   <= pend_in;
         region_ff <= region_in;
         target_ff <= target_in;
         sum_ff    <= sum_in;
         cover_ff  <= cover_in;
         reads_ff  <= reads_in;
         err_ff    <= err_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      wr_addr_ff <= wr_addr_in;
      prod_ff    <= prod_in;
   end

   // depth store: registered read, separate write
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= depth_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_waddr] <= mem_wdata;
      end
   end

   // response fields hold the totals; the flag compares sum * 256 with
   // target * covered, both exact
   assign rsp_reads_seen        = reads_ff;
   assign rsp_total_depth       = sum_ff;
   assign rsp_covered_positions = cover_ff;
   assign rsp_range_error       = err_ff;
   assign rsp_target_reached    = (cover_ff != '0) &&
                                  ({sum_ff, FRAC_BITS'(0)} >= CMP_BITS'(prod_ff));

   // every covered position holds depth of at least one
   `ASSERT_CLKRST(a_cover_le_sum, clock, reset, (SUM_BITS'(cover_ff) <= sum_ff))
   // a response always follows the multiply step
   `ASSERT_CLKRST(a_resp_after_mul, clock, reset, (rsp_valid |-> $past(state_ff == ST_MUL)))
   // the write-back trails the read issue by exactly one position
   `ASSERT_CLKRST(a_rmw_order, clock, reset,
      ((state_ff == ST_RUN && pend_ff && remain_ff != '0) |->
       (addr_ff == wr_addr_ff + POS_BITS'(1))))
   // a rejected read leaves the totals alone
   `ASSERT_CLKRST(a_err_no_update, clock, reset, ((state_ff == ST_MUL && err_ff) |-> $stable(sum_ff)))

endmodule

// ----- dv/read_coverage_depth_tracker_top_tb.sv -----
`timescale 1ns / 100ps

module read_coverage_depth_tracker_top_tb;

   import rcdt_pkg::*;

   // well above the slowest expected run (clearing pass, long directed
   // requests, random requests with sender gaps)
   localparam int unsigned CYCLE_LIMIT      = 4_000_000;
   localparam int unsigned RANDOM_PHASES    = 4;
   localparam int unsigned PHASE_REQUESTS   = 490;

   typedef struct packed {
      logic [START_BITS-1:0]  first_pos;
      logic [LENGTH_BITS-1:0] span;
   } read_item_type;

   typedef struct packed {
      logic [READS_BITS-1:0] reads_seen;
      logic [SUM_BITS-1:0]   total_depth;
      logic [COVER_BITS-1:0] covered_positions;
      logic                  target_reached;
      logic                  range_error;
   } coverage_totals_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // block ports, inputs all known from time zero
   logic                      start            = 1'b0;
   logic                      busy;
   logic [START_BITS-1:0]     req_read_start   = '0;
   logic [LENGTH_BITS-1:0]    req_read_length  = '0;
   logic                      rsp_valid;
   logic [READS_BITS-1:0]     rsp_reads_seen;
   logic [SUM_BITS-1:0]       rsp_total_depth;
   logic [COVER_BITS-1:0]     rsp_covered_positions;
   logic                      rsp_target_reached;
   logic                      rsp_range_error;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data   = '0;

   read_coverage_depth_tracker_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_read_start        (req_read_start),
      .req_read_length       (req_read_length),
      .rsp_valid             (rsp_valid),
      .rsp_reads_seen        (rsp_reads_seen),
      .rsp_total_depth       (rsp_total_depth),
      .rsp_covered_positions (rsp_covered_positions),
      .rsp_target_reached    (rsp_target_reached),
      .rsp_range_error       (rsp_range_error),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // predicted block state: depths and totals zero like the store after its clearing pass, registers at reset values
   bit [DEPTH_BITS-1:0]   depth_mem [POSITIONS];
   bit [SUM_BITS-1:0]     depth_total;
   bit [COVER_BITS-1:0]   covered_cnt;
   bit [READS_BITS-1:0]   read_cnt;
   logic [REGION_BITS-1:0] region_reg = REGION_RESET;
   logic [TARGET_BITS-1:0] target_reg = TARGET_RESET;

   read_item_type       pending_reads [$];
   coverage_totals_type expected_totals [$];
   read_item_type       inflight;

   int unsigned sender_idle_pct = 0;
   int unsigned error_count     = 0;
   int unsigned cycle_count     = 0;

   // region register clamped to the size of the depth store
   function automatic int unsigned region_span();
      return (32'(region_reg) > POSITIONS) ? POSITIONS : 32'(region_reg);
   endfunction

   // update the predicted depths for one accepted request and queue its totals
   function automatic void apply_read(input read_item_type item);
      coverage_totals_type totals;
      int unsigned         stop;
      int unsigned         pos;
      logic [POS_BITS-1:0] idx;
      stop = 32'(item.first_pos) + 32'(item.span);
      totals.range_error = (stop > region_span());
      // out of range requests leave every counter alone
      if (!totals.range_error) begin
         for (pos = 32'(item.first_pos); pos < stop; pos++) begin
            idx = POS_BITS'(pos);
            // a saturated counter adds nothing more to the sum
            if (depth_mem[idx] != '1) begin
               if (depth_mem[idx] == '0 && covered_cnt != '1)
                  covered_cnt++;
               depth_mem[idx]++;
               if (depth_total != '1)
                  depth_total++;
            end
         end
         if (read_cnt != '1)
            read_cnt++;
      end
      totals.reads_seen        = read_cnt;
      totals.total_depth       = depth_total;
      totals.covered_positions = covered_cnt;
      // exact compare of the 8.8 target against the mean over covered positions
      totals.target_reached = (covered_cnt != '0) &&
         (64'(depth_total) * 64'd256 >= 64'(target_reg) * 64'(covered_cnt));
      expected_totals.push_back(totals);
   endfunction

   task automatic add_read(input logic [START_BITS-1:0] first_pos,
                           input logic [LENGTH_BITS-1:0] span);
      read_item_type item;
      item.first_pos = first_pos;
      item.span      = span;
      pending_reads.push_back(item);
   endtask

   // mostly fitting fragments of typical length, some boundary misses and noise
   task automatic add_random_read();
      int unsigned limit;
      int unsigned roll;
      int unsigned span;
      int unsigned first;
      logic [31:0] noise;
      limit = region_span();
      roll  = $urandom_range(999);
      if (roll < 150) begin
         // raw field values, mostly out of range
         noise = $urandom;
         add_read(noise[START_BITS-1:0], noise[START_BITS+LENGTH_BITS-1:START_BITS]);
      end else begin
         if (roll < 152)
            span = limit;
         else if (roll < 250)
            span = $urandom_range(8);
         else if (roll < 300)
            span = $urandom_range(2000, 151);
         else
            span = $urandom_range(150, 1);
         if (span > limit)
            span = limit;
         // just one past the region end
         if (roll >= 950 && span != 0)
            first = limit - span + 1;
         else
            first = $urandom_range(limit - span);
         if (first > POSITIONS - 1)
            first = POSITIONS - 1;
         add_read(first[START_BITS-1:0], span[LENGTH_BITS-1:0]);
      end
   endtask

   // register write while the block is idle, mirrored into the prediction
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0]  value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      if (index == CSR_REGION)
         region_reg = value[REGION_BITS-1:0];
      else
         target_reg = value[TARGET_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // hold until every queued request is answered and the block went idle
   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (start || busy || pending_reads.size() != 0 || expected_totals.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // request driver: takes the next pending read, with random sender gaps
   always @(posedge clock) begin : request_driver
      logic launch;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         // a request on the ports is taken at this edge
         if (start)
            apply_read(inflight);
         launch = pending_reads.size() != 0 && $urandom_range(99) >= sender_idle_pct;
         if (launch) begin
            inflight = pending_reads.pop_front();
            req_read_start  <= inflight.first_pos;
            req_read_length <= inflight.span;
         end else begin
            // junk on the data ports while start is low
            req_read_start  <= START_BITS'($urandom);
            req_read_length <= LENGTH_BITS'($urandom);
         end
         start <= launch;
      end
   end

   // response monitor: every strobe is matched against the oldest prediction
   always @(posedge clock) begin : response_monitor
      coverage_totals_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_totals.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_totals.pop_front();
            if (rsp_reads_seen !== want.reads_seen) begin
               $error("reads_seen: expected %0d, got %0d", want.reads_seen, rsp_reads_seen);
               error_count++;
            end
            if (rsp_total_depth !== want.total_depth) begin
               $error("total_depth: expected %0d, got %0d", want.total_depth,
                      rsp_total_depth);
               error_count++;
            end
            if (rsp_covered_positions !== want.covered_positions) begin
               $error("covered_positions: expected %0d, got %0d", want.covered_positions,
                      rsp_covered_positions);
               error_count++;
            end
            if (rsp_target_reached !== want.target_reached) begin
               $error("target_reached: expected %0d, got %0d", want.target_reached,
                      rsp_target_reached);
               error_count++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("range_error: expected %0d, got %0d", want.range_error,
                      rsp_range_error);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned n;
      logic [CSR_DATA_BITS-1:0] region_val;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: region of 10000, target 2.0
      add_read(14'd0, 15'd0);          // empty request before any coverage
      add_read(14'd10001, 15'd0);      // empty request starting past the region
      add_read(14'd10000, 15'd0);      // empty request ending right at the region end
      add_read(14'd0, 15'd1);
      add_read(14'd9999, 15'd1);       // last position of the region
      add_read(14'd9999, 15'd2);       // one past the end
      add_read(14'd9990, 15'd10);
      add_read(14'd0, 15'd10000);      // whole region
      add_read(14'h3FFF, 15'h7FFF);    // both fields at their maximum
      add_read(14'd0, 15'd16384);
      wait_idle();

      // zero region, zero target: flag follows any coverage
      write_register(CSR_TARGET, 16'h0000);
      write_register(CSR_REGION, 16'h0000);
      add_read(14'd0, 15'd0);
      add_read(14'd0, 15'd1);
      add_read(14'd1, 15'd0);
      wait_idle();

      // all-ones region clamps to the store size, highest target
      write_register(CSR_REGION, 16'hFFFF);
      write_register(CSR_TARGET, 16'hFFFF);
      add_read(14'd16383, 15'd1);
      add_read(14'd0, 15'd16384);
      add_read(14'd16380, 15'd5);
      wait_idle();

      // one-position region, earlier depths outside it stay counted
      write_register(CSR_REGION, 16'd1);
      write_register(CSR_TARGET, TARGET_RESET);
      add_read(14'd0, 15'd1);
      add_read(14'd1, 15'd0);
      add_read(14'd0, 15'd2);
      wait_idle();

      // random phases, each with its own settings and sender gap rate
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               region_val      = 16'd16384;
               sender_idle_pct = 0;
            end
            1: begin
               region_val      = CSR_DATA_BITS'($urandom_range(16384, 64));
               sender_idle_pct = 61;
            end
            2: begin
               region_val      = 16'hFFFF;
               sender_idle_pct = 28;
            end
            default: begin
               region_val      = CSR_DATA_BITS'(REGION_RESET);
               sender_idle_pct = 0;
            end
         endcase
         write_register(CSR_REGION, region_val);
         write_register(CSR_TARGET, CSR_DATA_BITS'($urandom_range(3072, 128)));
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            // sender holds off mid-phase until everything is answered
            if (phase == 1 && n == PHASE_REQUESTS / 2)
               wait_idle();
            add_random_read();
         end
         wait_idle();
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
